FILE: hw/rtl/qoi_enc_pkg.sv
// QOI encoder package: pixel type, chunk opcodes, header bytes, register map and hash.
// Has no dependencies. The top level of the encoder and its testbench import it.
package qoi_enc_pkg;

    // Color index geometry.
    localparam int INDEX_ENTRIES = 64;
    localparam int IDX_W         = $clog2(INDEX_ENTRIES);

    // A run chunk covers at most this many pixels.
    localparam logic [5:0] RUN_LIMIT = 6'd62;

    // Chunk tags.
    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [1:0] OP_RUN2  = 2'b11;
    localparam logic [7:0] OP_RGB   = 8'hfe;
    localparam logic [7:0] OP_RGBA  = 8'hff;

    // Header magic "qoif" and the number of header and end-marker bytes.
    localparam logic [7:0] MAGIC_Q  = 8'h71;
    localparam logic [7:0] MAGIC_O  = 8'h6f;
    localparam logic [7:0] MAGIC_I  = 8'h69;
    localparam logic [7:0] MAGIC_F  = 8'h66;
    localparam logic [3:0] HDR_LEN  = 4'd14;
    localparam logic [3:0] END_LEN  = 4'd8;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;
    localparam logic [1:0] REG_COLORSP  = 2'd3;

    // Channel count that selects RGBA input.
    localparam logic [2:0] CH_RGBA = 3'd4;

    // Output segments of one pixel's byte sequence, in stream order.
    localparam logic [1:0] SEG_HDR = 2'd0;
    localparam logic [1:0] SEG_RUN = 2'd1;
    localparam logic [1:0] SEG_CHK = 2'd2;
    localparam logic [1:0] SEG_END = 2'd3;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    // Previous pixel at the start of an image: black, opaque.
    localparam t_pixel PREV_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

    // Index position: (3r + 5g + 7b + 11a) mod 64, kept in the index width.
    function automatic logic [IDX_W-1:0] qoi_hash(input t_pixel p);
        logic [IDX_W-1:0] h;
        h = p.r[IDX_W-1:0] * IDX_W'(3) + p.g[IDX_W-1:0] * IDX_W'(5)
          + p.b[IDX_W-1:0] * IDX_W'(7) + p.a[IDX_W-1:0] * IDX_W'(11);
        return h;
    endfunction

endpackage

FILE: hw/rtl/qoi_image_encoder_top.sv
// QOI image encoder: RGBA pixel stream in, QOI byte stream out.
// A pixel goes through the stage 1 and emitter job registers to the output register.
// Throughput: the emitter moves one byte per cycle when m_axis_tready allows; a pixel
// with bytes waits in stage 1 until it is free; if none waits, run pixels go one per cycle.
// Reset: synchronous, active low; clears the index valid bits, previous pixel, run and
// header state, and restores the registers to width 1, height 1, four channels, sRGB.
// Depends on qoi_enc_pkg and qoi_enc_ram.
module qoi_image_encoder_top
    import qoi_enc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  logic        s_axis_tlast,   // final_pixel
    // Byte output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
    output logic        m_axis_tlast,   // stream_end
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [2:0]  r_channels;
    logic        r_colorsp;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 16'd1;
            r_height   <= 16'd1;
            r_channels <= CH_RGBA;
            r_colorsp  <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:    r_width    <= pwdata[15:0];
                REG_HEIGHT:   r_height   <= pwdata[15:0];
                REG_CHANNELS: r_channels <= pwdata[2:0];
                REG_COLORSP:  r_colorsp  <= pwdata[0];
                default:      r_colorsp  <= r_colorsp;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:    prdata = {16'd0, r_width};
            REG_HEIGHT:   prdata = {16'd0, r_height};
            REG_CHANNELS: prdata = {29'd0, r_channels};
            REG_COLORSP:  prdata = {31'd0, r_colorsp};
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 0: accept a pixel, run tracking, index read
    // ------------------------------------------------------------------
    t_pixel             r_prev;
    logic [5:0]         r_run;
    logic               r_hdr_done;
    logic [INDEX_ENTRIES-1:0] r_valid;

    t_pixel             w_pix;
    logic               w_accept;
    logic               w_eq;
    logic [5:0]         w_run_inc;
    logic               w_run_en;
    logic [7:0]         w_run_byte;
    logic [5:0]         n_run;
    logic [IDX_W-1:0]   w_slot;

    // Stage 1 registers
    logic               r_s1_valid;
    logic               r_s1_hdr;
    logic               r_s1_run_en;
    logic [7:0]         r_s1_run_byte;
    logic               r_s1_chunk;
    logic               r_s1_final;
    t_pixel             r_s1_pix;
    t_pixel             r_s1_prev;
    logic [IDX_W-1:0]   r_s1_slot;
    logic               r_s1_fwd;
    t_pixel             r_s1_fwd_data;
    logic               r_s1_vld;
    logic               w_s1_handoff;
    logic               w_ram_we;
    logic [31:0]        w_ram_q;

    // In three-channel mode the previous alpha is carried over.
    always_comb begin
        w_pix.r = s_axis_tdata[7:0];
        w_pix.g = s_axis_tdata[15:8];
        w_pix.b = s_axis_tdata[23:16];
        w_pix.a = (r_channels == CH_RGBA) ? s_axis_tdata[31:24] : r_prev.a;
    end

    assign s_axis_tready = !r_s1_valid || w_s1_handoff;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_eq          = (w_pix == r_prev);
    assign w_run_inc     = r_run + 6'd1;
    assign w_slot        = qoi_hash(w_pix);

    // A repeated pixel extends the run; a run closes at its limit, at the last pixel,
    // or ahead of a different pixel.
    always_comb begin
        if (w_eq) begin
            w_run_en   = (w_run_inc >= RUN_LIMIT) || s_axis_tlast;
            w_run_byte = {OP_RUN2, r_run};
            n_run      = w_run_en ? 6'd0 : w_run_inc;
        end else begin
            w_run_en   = (r_run != 6'd0);
            w_run_byte = {OP_RUN2, r_run - 6'd1};
            n_run      = 6'd0;
        end
    end

    // Image state; the last pixel returns everything to the start-of-image values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= PREV_RESET;
            r_run      <= 6'd0;
            r_hdr_done <= 1'b0;
        end else if (w_accept) begin
            if (s_axis_tlast) begin
                r_prev     <= PREV_RESET;
                r_run      <= 6'd0;
                r_hdr_done <= 1'b0;
            end else begin
                r_prev     <= w_pix;
                r_run      <= n_run;
                r_hdr_done <= 1'b1;
            end
        end
    end

    // Index valid bits: a clear at the last pixel wins over a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_accept && s_axis_tlast) begin
            r_valid <= '0;
        end else if (w_ram_we) begin
            r_valid[r_s1_slot] <= 1'b1;
        end
    end

    qoi_enc_ram #(
        .WIDTH (32),
        .DEPTH (INDEX_ENTRIES)
    ) u_index (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s1_slot),
        .i_wdata (r_s1_pix),
        .i_re    (w_accept),
        .i_raddr (w_slot),
        .o_rdata (w_ram_q)
    );

    // Stage 1 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_handoff) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload; a write to the same slot in this cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_hdr      <= !r_hdr_done;
            r_s1_run_en   <= w_run_en;
            r_s1_run_byte <= w_run_byte;
            r_s1_chunk    <= !w_eq;
            r_s1_final    <= s_axis_tlast;
            r_s1_pix      <= w_pix;
            r_s1_prev     <= r_prev;
            r_s1_slot     <= w_slot;
            r_s1_fwd      <= w_ram_we && (r_s1_slot == w_slot);
            r_s1_fwd_data <= r_s1_pix;
            r_s1_vld      <= r_valid[w_slot];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: index compare and chunk selection
    // ------------------------------------------------------------------
    t_pixel            w_entry;
    logic              w_hit;
    logic signed [7:0] w_vr;
    logic signed [7:0] w_vg;
    logic signed [7:0] w_vb;
    logic signed [7:0] w_vgr;
    logic signed [7:0] w_vgb;
    logic [7:0]        w_dr;
    logic [7:0]        w_dg;
    logic [7:0]        w_db;
    logic [7:0]        w_lgr;
    logic [7:0]        w_lgb;
    logic [7:0]        w_lg;
    logic [2:0]        w_len;
    logic [4:0][7:0]   w_chk;
    logic [3:0]        w_pres;

    always_comb begin
        if (r_s1_fwd) begin
            w_entry = r_s1_fwd_data;
        end else if (r_s1_vld) begin
            w_entry = w_ram_q;
        end else begin
            w_entry = '0;
        end
    end

    assign w_hit = (w_entry == r_s1_pix);

    // Wrapped channel differences.
    assign w_vr  = $signed(r_s1_pix.r - r_s1_prev.r);
    assign w_vg  = $signed(r_s1_pix.g - r_s1_prev.g);
    assign w_vb  = $signed(r_s1_pix.b - r_s1_prev.b);
    assign w_vgr = w_vr - w_vg;
    assign w_vgb = w_vb - w_vg;
    assign w_dr  = w_vr + 8'sd2;
    assign w_dg  = w_vg + 8'sd2;
    assign w_db  = w_vb + 8'sd2;
    assign w_lg  = w_vg + 8'sd32;
    assign w_lgr = w_vgr + 8'sd8;
    assign w_lgb = w_vgb + 8'sd8;

    // Chunk bytes for a pixel that differs from its predecessor.
    always_comb begin
        w_chk = '0;
        w_len = 3'd0;
        if (r_s1_chunk) begin
            if (w_hit) begin
                w_chk[0] = OP_INDEX | 8'(r_s1_slot);
                w_len    = 3'd1;
            end else if (r_s1_pix.a != r_s1_prev.a) begin
                w_chk = {r_s1_pix.a, r_s1_pix.b, r_s1_pix.g, r_s1_pix.r, OP_RGBA};
                w_len = 3'd5;
            end else if (w_vr > -8'sd3 && w_vr < 8'sd2 && w_vg > -8'sd3 && w_vg < 8'sd2
                         && w_vb > -8'sd3 && w_vb < 8'sd2) begin
                w_chk[0] = OP_DIFF | {2'b00, w_dr[1:0], w_dg[1:0], w_db[1:0]};
                w_len    = 3'd1;
            end else if (w_vgr > -8'sd9 && w_vgr < 8'sd8 && w_vg > -8'sd33 && w_vg < 8'sd32
                         && w_vgb > -8'sd9 && w_vgb < 8'sd8) begin
                w_chk[0] = OP_LUMA | {2'b00, w_lg[5:0]};
                w_chk[1] = {w_lgr[3:0], w_lgb[3:0]};
                w_len    = 3'd2;
            end else begin
                w_chk[0] = OP_RGB;
                w_chk[1] = r_s1_pix.r;
                w_chk[2] = r_s1_pix.g;
                w_chk[3] = r_s1_pix.b;
                w_len    = 3'd4;
            end
        end
    end

    assign w_pres = {r_s1_final, (w_len != 3'd0), r_s1_run_en, r_s1_hdr};

    // ------------------------------------------------------------------
    // Byte emitter: header, run, chunk and end marker segments
    // ------------------------------------------------------------------
    logic            r_job_busy;
    logic [1:0]      r_seg;
    logic [3:0]      r_idx;
    logic [3:0]      r_pres;
    logic [7:0]      r_run_byte;
    logic [4:0][7:0] r_chk;
    logic [2:0]      r_len;
    logic            r_out_valid;
    logic [7:0]      r_out_data;
    logic            r_out_last;

    logic            w_emit;
    logic [3:0]      w_seg_len;
    logic            w_seg_last;
    logic            w_nxt_ok;
    logic [1:0]      w_nxt_seg;
    logic            w_job_done;
    logic            w_job_free;
    logic            w_load;
    logic [1:0]      w_first_seg;
    logic [7:0]      w_byte;
    logic            w_byte_last;

    assign w_emit     = r_job_busy && (!r_out_valid || m_axis_tready);
    assign w_job_done = w_emit && w_seg_last && !w_nxt_ok;
    assign w_job_free = !r_job_busy || w_job_done;

    // Stage 1 moves on when it has nothing to send or the emitter takes its bytes.
    assign w_s1_handoff = r_s1_valid && ((w_pres == 4'd0) || w_job_free);
    assign w_load       = w_s1_handoff && (w_pres != 4'd0);
    assign w_ram_we     = w_s1_handoff && r_s1_chunk && !w_hit && !r_s1_final;

    // Length of the current segment.
    always_comb begin
        case (r_seg)
            SEG_HDR: w_seg_len = HDR_LEN;
            SEG_RUN: w_seg_len = 4'd1;
            SEG_CHK: w_seg_len = {1'b0, r_len};
            default: w_seg_len = END_LEN;
        endcase
    end

    assign w_seg_last = (r_idx == w_seg_len - 4'd1);

    // Next present segment after the current one, and the first one of a new job.
    always_comb begin
        w_nxt_ok    = 1'b0;
        w_nxt_seg   = r_seg;
        w_first_seg = SEG_END;
        for (int i = 3; i >= 0; i--) begin
            if (r_pres[i] && (2'(i) > r_seg)) begin
                w_nxt_ok  = 1'b1;
                w_nxt_seg = 2'(i);
            end
            if (w_pres[i]) begin
                w_first_seg = 2'(i);
            end
        end
    end

    // Current byte of the stream.
    always_comb begin
        w_byte      = 8'd0;
        w_byte_last = 1'b0;
        case (r_seg)
            SEG_HDR: begin
                case (r_idx)
                    4'd0:    w_byte = MAGIC_Q;
                    4'd1:    w_byte = MAGIC_O;
                    4'd2:    w_byte = MAGIC_I;
                    4'd3:    w_byte = MAGIC_F;
                    4'd6:    w_byte = r_width[15:8];
                    4'd7:    w_byte = r_width[7:0];
                    4'd10:   w_byte = r_height[15:8];
                    4'd11:   w_byte = r_height[7:0];
                    4'd12:   w_byte = {5'd0, r_channels};
                    4'd13:   w_byte = {7'd0, r_colorsp};
                    default: w_byte = 8'd0;
                endcase
            end
            SEG_RUN: w_byte = r_run_byte;
            SEG_CHK: w_byte = r_chk[r_idx[2:0]];
            default: begin
                w_byte      = {7'd0, w_seg_last};
                w_byte_last = w_seg_last;
            end
        endcase
    end

    // Emitter sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_busy <= 1'b0;
            r_seg      <= SEG_HDR;
            r_idx      <= 4'd0;
            r_pres     <= 4'd0;
        end else if (w_load) begin
            r_job_busy <= 1'b1;
            r_seg      <= w_first_seg;
            r_idx      <= 4'd0;
            r_pres     <= w_pres;
        end else if (w_job_done) begin
            r_job_busy <= 1'b0;
        end else if (w_emit) begin
            if (w_seg_last) begin
                r_seg <= w_nxt_seg;
                r_idx <= 4'd0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_run_byte <= r_s1_run_byte;
            r_chk      <= w_chk;
            r_len      <= w_len;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_byte;
            r_out_last <= w_byte_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run < RUN_LIMIT)
        else $error("run counter reached the run limit");

    a_image_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tlast |=> r_prev == PREV_RESET && r_run == 6'd0
            && !r_hdr_done && r_valid == '0)
        else $error("encoder state not restored after the last pixel");

    a_seg_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_busy |-> r_pres[r_seg])
        else $error("emitter is in a segment the job does not have");

    a_hit_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_chunk && w_hit |-> !w_ram_we)
        else $error("index written on a hit");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_job_free)
        else $error("emitter job overwritten while busy");

endmodule

FILE: hw/rtl/qoi_enc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the encoder uses it for the color index.
module qoi_enc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/qoi_enc_checker.sv
// Scoreboard for the QOI image encoder: follows the pixel, byte and register channels,
// predicts the encoded byte stream and compares every output byte with it.
// Depends on qoi_enc_pkg for the pixel type, chunk tags and register indexes.
`timescale 1ns / 100ps

module qoi_enc_checker
    import qoi_enc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  logic        s_axis_tlast,   // final_pixel
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // out_byte [7:0]
    input  logic        m_axis_tlast,   // stream_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    // Last byte of the end marker; the seven before it are zero.
    localparam logic [7:0] END_MARK_TAIL = 8'h01;

    t_stream_byte stream_q[$];
    t_pixel       color_seen [INDEX_ENTRIES];
    t_pixel       prev_px;
    int unsigned  run_len;
    logic         header_sent;
    logic [15:0]  cfg_width;
    logic [15:0]  cfg_height;
    logic [2:0]   cfg_channels;
    logic         cfg_colorsp;
    int           fail_cnt = 0;
    int           byte_no  = 0;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Low eight bits of a difference, read as a signed byte.
    function automatic int wrap_diff(input int v);
        logic [7:0] low8;
        low8 = 8'(v);
        return int'($signed(low8));
    endfunction

    function automatic void emit_byte(input logic [7:0] data, input logic last);
        t_stream_byte rec;
        rec.data = data;
        rec.last = last;
        stream_q.push_back(rec);
    endfunction

    // Encoder state at the start of every image.
    function automatic void restart_image();
        for (int i = 0; i < INDEX_ENTRIES; i++) color_seen[i] = '0;
        prev_px     = PREV_RESET;
        run_len     = 0;
        header_sent = 1'b0;
    endfunction

    function automatic void close_run();
        emit_byte({OP_RUN2, 6'(run_len - 1)}, 1'b0);
        run_len = 0;
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_WIDTH:    return {16'd0, cfg_width};
            REG_HEIGHT:   return {16'd0, cfg_height};
            REG_CHANNELS: return {29'd0, cfg_channels};
            REG_COLORSP:  return {31'd0, cfg_colorsp};
            default:      return '0;
        endcase
    endfunction

    // Bytes that one accepted pixel adds to the stream.
    function automatic void encode_pixel(input logic [31:0] data, input logic final_px);
        t_pixel px;
        int     slot;
        int     dr;
        int     dg;
        int     db;
        int     dgr;
        int     dgb;
        px.r = data[7:0];
        px.g = data[15:8];
        px.b = data[23:16];
        // Only four-channel mode takes alpha from the input.
        px.a = (cfg_channels == CH_RGBA) ? data[31:24] : prev_px.a;

        if (!header_sent) begin
            emit_byte(MAGIC_Q, 1'b0);
            emit_byte(MAGIC_O, 1'b0);
            emit_byte(MAGIC_I, 1'b0);
            emit_byte(MAGIC_F, 1'b0);
            emit_byte(8'h00, 1'b0);
            emit_byte(8'h00, 1'b0);
            emit_byte(cfg_width[15:8], 1'b0);
            emit_byte(cfg_width[7:0], 1'b0);
            emit_byte(8'h00, 1'b0);
            emit_byte(8'h00, 1'b0);
            emit_byte(cfg_height[15:8], 1'b0);
            emit_byte(cfg_height[7:0], 1'b0);
            emit_byte({5'd0, cfg_channels}, 1'b0);
            emit_byte({7'd0, cfg_colorsp}, 1'b0);
            header_sent = 1'b1;
        end

        if (px == prev_px) begin
            run_len++;
            if (run_len >= RUN_LIMIT || final_px) close_run();
        end else begin
            if (run_len > 0) close_run();
            slot = (3 * px.r + 5 * px.g + 7 * px.b + 11 * px.a) % INDEX_ENTRIES;
            if (color_seen[slot] == px) begin
                emit_byte(OP_INDEX | 8'(slot), 1'b0);
            end else begin
                color_seen[slot] = px;
                if (px.a == prev_px.a) begin
                    dr  = wrap_diff(int'(px.r) - int'(prev_px.r));
                    dg  = wrap_diff(int'(px.g) - int'(prev_px.g));
                    db  = wrap_diff(int'(px.b) - int'(prev_px.b));
                    dgr = wrap_diff(dr - dg);
                    dgb = wrap_diff(db - dg);
                    if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
                        emit_byte(OP_DIFF | 8'((dr + 2) * 16 + (dg + 2) * 4 + (db + 2)), 1'b0);
                    end else if (dgr >= -8 && dgr <= 7 && dg >= -32 && dg <= 31
                                 && dgb >= -8 && dgb <= 7) begin
                        emit_byte(OP_LUMA | 8'(dg + 32), 1'b0);
                        emit_byte(8'((dgr + 8) * 16 + (dgb + 8)), 1'b0);
                    end else begin
                        emit_byte(OP_RGB, 1'b0);
                        emit_byte(px.r, 1'b0);
                        emit_byte(px.g, 1'b0);
                        emit_byte(px.b, 1'b0);
                    end
                end else begin
                    emit_byte(OP_RGBA, 1'b0);
                    emit_byte(px.r, 1'b0);
                    emit_byte(px.g, 1'b0);
                    emit_byte(px.b, 1'b0);
                    emit_byte(px.a, 1'b0);
                end
            end
        end
        prev_px = px;

        // The end marker closes the image and the state starts over.
        if (final_px) begin
            for (int i = 0; i < int'(END_LEN) - 1; i++) emit_byte(8'h00, 1'b0);
            emit_byte(END_MARK_TAIL, 1'b1);
            restart_image();
        end
    endfunction

    // Sample all channels at the clock edge, retiring bytes before adding new ones.
    always @(posedge i_clk) begin
        t_stream_byte want;
        if (!i_rst_n) begin
            stream_q.delete();
            restart_image();
            cfg_width    = 16'd1;
            cfg_height   = 16'd1;
            cfg_channels = CH_RGBA;
            cfg_colorsp  = 1'b0;
        end else begin
            // Register requests update the configuration copy or are checked on read.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_WIDTH:    cfg_width    = pwdata[15:0];
                        REG_HEIGHT:   cfg_height   = pwdata[15:0];
                        REG_CHANNELS: cfg_channels = pwdata[2:0];
                        REG_COLORSP:  cfg_colorsp  = pwdata[0];
                        default: ;
                    endcase
                end else if (prdata !== reg_value(paddr[3:2])) begin
                    report_mismatch($sformatf("register %0d read 0x%08h, expected 0x%08h",
                                              paddr[3:2], prdata, reg_value(paddr[3:2])));
                end
            end

            // Each output byte is matched against the oldest expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                if (stream_q.size() == 0) begin
                    report_mismatch($sformatf("byte %0d = 0x%02h arrived with none expected",
                                              byte_no, m_axis_tdata));
                end else begin
                    want = stream_q.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        report_mismatch($sformatf("byte %0d data 0x%02h, expected 0x%02h",
                                                  byte_no, m_axis_tdata, want.data));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("byte %0d stream end %b, expected %b",
                                                  byte_no, m_axis_tlast, want.last));
                    end
                end
                byte_no++;
            end

            if (s_axis_tvalid && s_axis_tready) encode_pixel(s_axis_tdata, s_axis_tlast);
        end
        o_pending <= stream_q.size();
    end

endmodule

FILE: verif/tb_qoi_image_encoder_top.sv
// Testbench top for the QOI image encoder: clock, reset, pixel and register stimulus,
// random output back-pressure and the verdict. Checking is done by qoi_enc_checker.
// Depends on qoi_enc_pkg, qoi_enc_checker and qoi_image_encoder_top.
`timescale 1ns / 100ps

module tb_qoi_image_encoder_top;
    import qoi_enc_pkg::*;

    localparam int         CYCLE_LIMIT   = 2_000_000;
    localparam int         RANDOM_PIXELS = 380;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [2:0] CH_RGB        = 3'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    logic        s_axis_tlast;   // final_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // out_byte [7:0]
    logic        m_axis_tlast;   // stream_end
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int         fail_count;
    int         pending;
    int         cycle_cnt    = 0;
    int         pixels_sent  = 0;
    bit         calm         = 1'b0;
    logic [2:0] cur_channels = CH_RGBA;

    qoi_image_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    qoi_enc_checker stream_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Output back-pressure: bursts of ready broken by random stalls.
    initial begin
        int hold;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= 1'b1;
            hold = calm ? 40 : $urandom_range(1, 12);
            repeat (hold) @(posedge i_clk);
            hold = calm ? 0 : pick_gap();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_all_regs();
        apb_access(REG_WIDTH, 1'b0, '0);
        apb_access(REG_HEIGHT, 1'b0, '0);
        apb_access(REG_CHANNELS, 1'b0, '0);
        apb_access(REG_COLORSP, 1'b0, '0);
    endtask

    task automatic set_format(input logic [15:0] w, input logic [15:0] h,
                              input logic [2:0] ch, input logic cs);
        apb_access(REG_WIDTH, 1'b1, {16'd0, w});
        apb_access(REG_HEIGHT, 1'b1, {16'd0, h});
        apb_access(REG_CHANNELS, 1'b1, {29'd0, ch});
        apb_access(REG_COLORSP, 1'b1, {31'd0, cs});
        cur_channels = ch;
        read_all_regs();
    endtask

    // One pixel request; the pixel is given as {r, g, b, a}.
    task automatic send_pixel(input t_pixel px, input logic final_px);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.a, px.b, px.g, px.r};
        s_axis_tlast  <= final_px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected byte is out and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One image built from pixel steps that aim at each chunk kind.
    task automatic send_image(input int n_px);
        t_pixel base;
        t_pixel nxt;
        t_pixel px;
        t_pixel recent [8];
        int     left;
        int     kind;
        int     reps;
        int     dg;
        base = PREV_RESET;
        left = n_px;
        for (int i = 0; i < 8; i++) recent[i] = $urandom;
        while (left > 0) begin
            kind = $urandom_range(0, 99);
            reps = 1;
            nxt  = base;
            if (kind < 20) begin
                // Repeats, sometimes long enough to pass the run limit.
                reps = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(1, 4);
            end else if (kind < 40) begin
                nxt.r = base.r + 8'($urandom_range(0, 3)) - 8'd2;
                nxt.g = base.g + 8'($urandom_range(0, 3)) - 8'd2;
                nxt.b = base.b + 8'($urandom_range(0, 3)) - 8'd2;
            end else if (kind < 58) begin
                dg    = $urandom_range(0, 63) - 32;
                nxt.g = base.g + 8'(dg);
                nxt.r = base.r + 8'(dg + $urandom_range(0, 15) - 8);
                nxt.b = base.b + 8'(dg + $urandom_range(0, 15) - 8);
            end else if (kind < 72) begin
                nxt = recent[$urandom_range(0, 7)];
            end else if (kind < 86) begin
                nxt.r = 8'($urandom);
                nxt.g = 8'($urandom);
                nxt.b = 8'($urandom);
            end else if (kind < 94) begin
                nxt.a = 8'($urandom);
            end else begin
                nxt = $urandom;
            end
            while (reps > 0 && left > 0) begin
                px = nxt;
                if (cur_channels != CH_RGBA) px.a = 8'($urandom);
                send_pixel(px, left == 1);
                left--;
                reps--;
            end
            base = nxt;
            recent[$urandom_range(0, 7)] = nxt;
        end
    endtask

    function automatic logic [15:0] rand_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 16'd1;
        if (roll < 30) return 16'hffff;
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [2:0] rand_channels();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return CH_RGBA;
        if (roll < 85) return CH_RGB;
        return 3'($urandom_range(0, 7));
    endfunction

    // Reset, directed images, then random phases of format and images.
    initial begin
        int random_start;
        int phase;
        int n_imgs;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_all_regs();

        // Reset format, four channels. Starts on a pixel equal to the reset previous pixel.
        send_pixel({8'd0, 8'd0, 8'd0, 8'd255}, 1'b0);
        send_pixel({8'd0, 8'd0, 8'd0, 8'd255}, 1'b0);
        // Small differences, both wrapping around 0 and 255.
        send_pixel({8'd1, 8'd0, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd255, 8'd254, 8'd0, 8'd255}, 1'b0);
        // Luma, then luma at both ends of its ranges.
        send_pixel({8'd5, 8'd10, 8'd5, 8'd255}, 1'b0);
        send_pixel({8'd221, 8'd234, 8'd236, 8'd255}, 1'b0);
        send_pixel({8'd3, 8'd9, 8'd3, 8'd255}, 1'b0);
        // Full color, then alpha change, then a hit on index slot zero.
        send_pixel({8'd100, 8'd0, 8'd200, 8'd255}, 1'b0);
        send_pixel({8'd100, 8'd0, 8'd200, 8'd0}, 1'b0);
        send_pixel({8'd3, 8'd9, 8'd3, 8'd255}, 1'b0);
        // A run closed by a new pixel, then a run closed by the last pixel.
        send_pixel({8'd255, 8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd255, 8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd255, 8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
        send_pixel({8'd0, 8'd0, 8'd0, 8'd0}, 1'b1);
        // Single-pixel image right after an image end.
        send_pixel({8'd0, 8'd0, 8'd0, 8'd255}, 1'b1);
        wait_idle();

        // Largest header sizes, three channels: the alpha input must have no effect.
        set_format(16'hffff, 16'hffff, CH_RGB, 1'b1);
        send_pixel({8'd7, 8'd7, 8'd7, 8'd0}, 1'b0);
        send_pixel({8'd7, 8'd7, 8'd7, 8'd123}, 1'b0);
        send_pixel({8'd8, 8'd7, 8'd7, 8'd200}, 1'b0);
        send_pixel({8'd8, 8'd7, 8'd7, 8'd17}, 1'b1);
        wait_idle();

        random_start = pixels_sent;
        phase = 0;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            // The first two phases pin the odd channel counts and the opposite size extremes.
            case (phase)
                0:       set_format(16'd1, 16'hffff, 3'd7, 1'b0);
                1:       set_format(16'hffff, 16'd1, 3'd0, 1'b1);
                default: set_format(rand_dim(), rand_dim(), rand_channels(),
                                    1'($urandom_range(0, 1)));
            endcase
            calm   = ($urandom_range(0, 4) == 0);
            n_imgs = $urandom_range(1, 3);
            for (int i = 0; i < n_imgs; i++) begin
                send_image(($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                       : $urandom_range(1, 20));
            end
            wait_idle();
            phase++;
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: qoi_image_encoder_top.f
hw/rtl/qoi_enc_pkg.sv
hw/rtl/qoi_enc_ram.sv
hw/rtl/qoi_image_encoder_top.sv
verif/qoi_enc_checker.sv
verif/tb_qoi_image_encoder_top.sv
